// ===== hw/rtl/bmhq_pkg.sv =====
// package for the binary max-heap priority queue
// holds widths, codes, controller states and the control/status structs
// no dependencies
package bmhq_pkg;

  localparam int KEY_W         = 32;
  localparam int CNT_W         = 5;
  localparam int STATUS_W      = 2;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // read address selection for port 0
  typedef enum logic [1:0] {
    RD_LAST,
    RD_PARENT,
    RD_CHILD
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    load_mv;
    logic    wr_en;
    logic    wr_mv;
    logic    idx_to_parent;
    logic    idx_to_child;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic cnt_zero;
    logic up_swap;
    logic go_child;
  } dp_status_t;

endpackage

// ===== hw/rtl/binary_max_heap_queue_top.sv =====
// binary max-heap priority queue, top level; depends on bmhq_pkg, bmhq_ctrl, bmhq_dp
// an insert sifts up one level per step, a remove sifts down one level per step
// a refused insert (full) or remove (empty) goes straight to the done strobe
// busy stays high until the done strobe cycle ends
// a new operation is taken the cycle after done; the receiver cannot stall
// sync reset empties the heap and sets capacity to 16; no clearing pass
module binary_max_heap_queue_top #(
  parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd,
  input  logic signed [bmhq_pkg::KEY_W-1:0]    key_in,
  input  logic                                 cfg_wr_en,
  input  logic        [bmhq_pkg::CNT_W-1:0]    cfg_wr_data,
  output logic                                 done,
  output logic        [bmhq_pkg::STATUS_W-1:0] status,
  output logic signed [bmhq_pkg::KEY_W-1:0]    removed_key,
  output logic signed [bmhq_pkg::KEY_W-1:0]    top_key,
  output logic                                 top_valid,
  output logic        [bmhq_pkg::CNT_W-1:0]    entry_total
);
  import bmhq_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // sequencer
  bmhq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // heap storage and compare logic
  bmhq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key_in      (key_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts),
    .status      (status),
    .removed_key (removed_key),
    .top_key     (top_key),
    .top_valid   (top_valid),
    .entry_total (entry_total)
  );

endmodule

// ===== hw/rtl/bmhq_dp.sv =====
// datapath of the heap queue: heap memory, moving key, index, count, capacity
// depends on bmhq_pkg
module bmhq_dp #(
  parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd,
  input  logic signed [bmhq_pkg::KEY_W-1:0]   key_in,
  input  logic                                cfg_wr_en,
  input  logic        [bmhq_pkg::CNT_W-1:0]   cfg_wr_data,
  input  bmhq_pkg::ctrl_cmd_t                 ctl,
  output bmhq_pkg::dp_status_t                sts,
  output logic        [bmhq_pkg::STATUS_W-1:0] status,
  output logic signed [bmhq_pkg::KEY_W-1:0]   removed_key,
  output logic signed [bmhq_pkg::KEY_W-1:0]   top_key,
  output logic                                top_valid,
  output logic        [bmhq_pkg::CNT_W-1:0]   entry_total
);
  import bmhq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = ((AW > CNT_W) ? AW : CNT_W) + 2;

  logic signed [KEY_W-1:0]    mem [DEPTH];
  logic signed [KEY_W-1:0]    rd0;
  logic signed [KEY_W-1:0]    rd1;
  logic signed [KEY_W-1:0]    mv;
  logic signed [KEY_W-1:0]    top_q;
  logic signed [KEY_W-1:0]    removed_q;
  logic [STATUS_W-1:0]        status_q;
  logic                       op_q;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           capacity;
  logic [IW-1:0]              idx;

  logic [IW-1:0]              cnt_ext;
  logic [IW-1:0]              parent;
  logic [IW-1:0]              lchild;
  logic [IW-1:0]              rchild;
  logic [IW-1:0]              ra0;
  logic [IW-1:0]              child_idx;
  logic                       l_big;
  logic                       r_big;
  logic signed [KEY_W-1:0]    cmp_val;
  logic signed [KEY_W-1:0]    child_data;
  logic signed [KEY_W-1:0]    wdata;
  logic                       full_now;

  // index arithmetic
  assign cnt_ext = IW'(count);
  assign parent  = (idx - IW'(1)) >> 1;
  assign lchild  = (idx << 1) + IW'(1);
  assign rchild  = (idx << 1) + IW'(2);

  always_comb begin
    case (ctl.rd_sel)
      RD_LAST:   ra0 = cnt_ext - IW'(1);
      RD_PARENT: ra0 = parent;
      RD_CHILD:  ra0 = lchild;
      default:   ra0 = lchild;
    endcase
  end

  // pick the greater child against the moving key, ties stay put
  assign l_big      = (lchild < cnt_ext) && (rd0 > mv);
  assign cmp_val    = l_big ? rd0 : mv;
  assign r_big      = (rchild < cnt_ext) && (rd1 > cmp_val);
  assign child_data = r_big ? rd1 : rd0;
  assign child_idx  = r_big ? rchild : lchild;

  assign wdata = ctl.wr_mv ? mv : ((op_q == OP_REMOVE) ? child_data : rd0);

  assign full_now = (cnt_ext >= IW'(capacity)) || (cnt_ext >= IW'(DEPTH));

  // status toward the controller
  assign sts.full     = full_now;
  assign sts.empty    = (count == '0);
  assign sts.idx_zero = (idx == '0);
  assign sts.cnt_zero = (count == '0);
  assign sts.up_swap  = (mv > rd0);
  assign sts.go_child = l_big || r_big;

  // heap memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[idx[AW-1:0]] <= wdata;
    end
    rd0 <= mem[ra0[AW-1:0]];
    rd1 <= mem[rchild[AW-1:0]];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.accept) begin
      if (cmd == OP_INSERT && !full_now) begin
        count <= count + CNT_W'(1);
      end else if (cmd == OP_REMOVE && count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // operation registers, moving key and index
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_q <= cmd;
      if (cmd == OP_INSERT) begin
        removed_q <= '0;
        if (full_now) begin
          status_q <= ST_FULL;
        end else begin
          status_q <= ST_OK;
          mv       <= key_in;
          idx      <= cnt_ext;
        end
      end else begin
        if (count == '0) begin
          status_q  <= ST_EMPTY;
          removed_q <= '0;
        end else begin
          status_q  <= ST_OK;
          removed_q <= top_q;
          idx       <= '0;
        end
      end
    end
    if (ctl.load_mv) begin
      mv <= rd0;
    end
    if (ctl.idx_to_parent) begin
      idx <= parent;
    end else if (ctl.idx_to_child) begin
      idx <= child_idx;
    end
    // shadow of the root entry
    if (ctl.wr_en && idx == '0) begin
      top_q <= wdata;
    end
  end

  // result fields
  assign status      = status_q;
  assign removed_key = removed_q;
  assign top_valid   = (count != '0);
  assign top_key     = (count != '0) ? top_q : '0;
  assign entry_total = count;

  // count stays within the heap depth
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= IW'(DEPTH))
    else $error("entry count beyond depth");

  // heap writes land inside the occupied region
  a_write_in_heap : assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (idx < cnt_ext))
    else $error("heap write outside occupied entries");

  // a refused insert leaves the count alone
  a_full_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && cmd == OP_INSERT && full_now) |=> (count == $past(count)))
    else $error("refused insert changed count");

  // sift-up only moves to a smaller index
  a_parent_moves_up : assert property (@(posedge clk) disable iff (rst)
    ctl.idx_to_parent |=> (idx < $past(idx)))
    else $error("sift-up index did not decrease");

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
// controller of the heap queue: sequences sift-up and sift-down steps
// depends on bmhq_pkg
module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 cmd,
  input  bmhq_pkg::dp_status_t sts,
  output bmhq_pkg::ctrl_cmd_t  ctl,
  output logic                 busy,
  output logic                 done
);
  import bmhq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next        = state;
    ctl               = '0;
    ctl.rd_sel        = RD_CHILD;
    done              = 1'b0;
    case (state)
      S_IDLE: begin
        ctl.rd_sel = RD_LAST;
        if (start) begin
          ctl.accept = 1'b1;
          if (cmd == OP_INSERT) begin
            state_next = sts.full ? S_DONE : S_UP_RD;
          end else begin
            state_next = sts.empty ? S_DONE : S_DN_LOAD;
          end
        end
      end
      S_UP_RD: begin
        ctl.rd_sel = RD_PARENT;
        if (sts.idx_zero) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_mv  = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        if (sts.up_swap) begin
          ctl.idx_to_parent = 1'b1;
          state_next        = S_UP_RD;
        end else begin
          ctl.wr_mv  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_LOAD: begin
        ctl.load_mv = 1'b1;
        state_next  = sts.cnt_zero ? S_DONE : S_DN_CMP;
      end
      S_DN_RD: begin
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        ctl.wr_en = 1'b1;
        if (sts.go_child) begin
          ctl.idx_to_child = 1'b1;
          state_next       = S_DN_RD;
        end else begin
          ctl.wr_mv  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // a write never happens while idle or reporting
  a_no_idle_write : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ctl.wr_en)
    else $error("heap write outside a sift");

  // every result strobe is followed by a return to idle
  a_done_to_idle : assert property (@(posedge clk) disable iff (rst)
    done |=> (state == S_IDLE))
    else $error("result strobe not followed by idle");

endmodule
